// File: src/sorted_interval_color_table_unit_macros.svh
// Assertion macros used by the interval table RTL.
`ifndef SORTED_INTERVAL_COLOR_TABLE_UNIT_MACROS_SVH
`define SORTED_INTERVAL_COLOR_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SICT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval table check failed");

// The consequent must hold in the cycle after the antecedent.
`define SICT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval table check failed");

`endif

// File: src/sict_pkg.sv
package sict_pkg;

  localparam int DEFAULT_MAX_INTERVALS = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERLAP   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] range_begin;
    logic               begin_inclusive;
    logic signed [31:0] range_end;
    logic               end_inclusive;
    logic [31:0]        entry_color;
    logic signed [31:0] probe_value;
    logic [3:0]         entry_index;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_color;
    logic [4:0]  entry_count;
  } result_t;

  typedef struct packed {
    logic signed [31:0] range_begin;
    logic signed [31:0] range_end;
    logic               begin_inclusive;
    logic               end_inclusive;
    logic [31:0]        color;
  } entry_t;

endpackage

// File: src/sorted_interval_color_table_unit.sv
// Sorted interval color table.
// An item is taken on cmd at a rising edge where start is high and busy is low.
// Operations are insert, lookup and remove-at-index; op code 3 does nothing.
// Each item yields exactly one result on result, marked by done for one cycle.
// The receiver cannot stall, so the result must be taken in that cycle.
// Items are handled one at a time; busy stays high until the result is shown.
// All entries live in one memory with a registered read port, which sets the pace:
// lookup reads the entries from the head one at a time until a match or the tail.
// Insert reads the tail, walks toward the head one entry per cycle, then
// shifts the later entries up one per cycle and writes the new entry.
// An overlap found on the walk ends the insert without a write.
// Remove shifts later entries down one per cycle.
// A full table, a bad index, op code 3, an empty lookup and tail removal never leave idle.
// Reset empties the table at once; no clearing pass runs over the memory.
// Shift reads and writes always touch different entries, so no forwarding is needed.
`include "sorted_interval_color_table_unit_macros.svh"

module sorted_interval_color_table_unit
  import sict_pkg::*;
#(
  parameter int MAX_INTERVALS = DEFAULT_MAX_INTERVALS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_EV,
    S_SH_RD,
    S_SH,
    S_WR,
    S_LK_EV,
    S_RM
  } state_t;

  state_t           state;
  cmd_t             req;
  logic [CNT_W-1:0] held_count;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] pos;

  entry_t           mem [MAX_INTERVALS];
  entry_t           rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  entry_t           new_entry;

  logic             is_below;
  logic             is_above;
  logic             is_hit;
  logic             k_is_tail;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cnt_ext;

  assign busy = (state != S_IDLE);

  assign new_entry = '{range_begin:     req.range_begin,
                       range_end:       req.range_end,
                       begin_inclusive: req.begin_inclusive,
                       end_inclusive:   req.end_inclusive,
                       color:           req.entry_color};

  // Ordering of the pending interval against the entry just read; below wins.
  assign is_above = (req.range_begin > rd_data.range_end) ||
                    ((req.range_begin == rd_data.range_end) &&
                     (!req.begin_inclusive || !rd_data.end_inclusive));
  assign is_below = (req.range_end < rd_data.range_begin) ||
                    ((req.range_end == rd_data.range_begin) &&
                     (!req.end_inclusive || !rd_data.begin_inclusive));

  assign is_hit = (rd_data.begin_inclusive ? (req.probe_value >= rd_data.range_begin)
                                           : (req.probe_value >  rd_data.range_begin)) &&
                  (rd_data.end_inclusive   ? (req.probe_value <= rd_data.range_end)
                                           : (req.probe_value <  rd_data.range_end));

  assign k_is_tail = ((CNT_W'(k) + CNT_ONE) == held_count);
  assign idx_ext   = CMP_W'(cmd.entry_index);
  assign cnt_ext   = CMP_W'(held_count);

  always_comb begin
    rd_addr = k;
    wr_en   = 1'b0;
    wr_addr = k;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        unique case (cmd.op)
          OP_INSERT: rd_addr = IDX_W'(held_count - CNT_ONE);
          OP_LOOKUP: rd_addr = '0;
          OP_REMOVE: rd_addr = IDX_W'(cmd.entry_index) + IDX_ONE;
          default:   rd_addr = k;
        endcase
      end
      S_INS_EV: rd_addr = k - IDX_ONE;
      S_SH_RD:  rd_addr = k - IDX_ONE;
      S_SH: begin
        rd_addr = k - IDX_ONE - IDX_ONE;
        wr_en   = 1'b1;
        wr_addr = k;
        wr_data = rd_data;
      end
      S_WR: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = new_entry;
      end
      S_LK_EV: rd_addr = k + IDX_ONE;
      S_RM: begin
        rd_addr = k + IDX_ONE + IDX_ONE;
        wr_en   = 1'b1;
        wr_addr = k;
        wr_data = rd_data;
      end
      default: rd_addr = k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      done       <= 1'b0;
      k          <= '0;
      pos        <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req                <= cmd;
            result.found_color <= '0;
            result.entry_count <= 5'(held_count);
            result.status      <= ST_OK;
            unique case (cmd.op)
              OP_INSERT: begin
                priority if (held_count == CNT_MAX) begin
                  result.status <= ST_FULL;
                  done          <= 1'b1;
                end else if (held_count == '0) begin
                  pos   <= '0;
                  state <= S_WR;
                end else begin
                  k     <= IDX_W'(held_count - CNT_ONE);
                  state <= S_INS_EV;
                end
              end
              OP_LOOKUP: begin
                if (held_count == '0) begin
                  result.status <= ST_NOT_FOUND;
                  done          <= 1'b1;
                end else begin
                  k     <= '0;
                  state <= S_LK_EV;
                end
              end
              OP_REMOVE: begin
                priority if (idx_ext >= cnt_ext) begin
                  result.status <= ST_BAD_INDEX;
                  done          <= 1'b1;
                end else if ((idx_ext + CMP_W'(1)) == cnt_ext) begin
                  held_count         <= held_count - CNT_ONE;
                  result.entry_count <= 5'(held_count - CNT_ONE);
                  done               <= 1'b1;
                end else begin
                  k     <= IDX_W'(cmd.entry_index);
                  state <= S_RM;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_INS_EV: begin
          priority if (is_below) begin
            if (k == '0) begin
              pos   <= '0;
              k     <= IDX_W'(held_count);
              state <= S_SH_RD;
            end else begin
              k <= k - IDX_ONE;
            end
          end else if (is_above) begin
            pos <= k + IDX_ONE;
            if (k_is_tail) begin
              state <= S_WR;
            end else begin
              k     <= IDX_W'(held_count);
              state <= S_SH_RD;
            end
          end else begin
            result.status <= ST_OVERLAP;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_SH_RD: state <= S_SH;
        S_SH: begin
          k <= k - IDX_ONE;
          if ((k - IDX_ONE) == pos) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          held_count         <= held_count + CNT_ONE;
          result.entry_count <= 5'(held_count + CNT_ONE);
          result.status      <= ST_OK;
          done               <= 1'b1;
          state              <= S_IDLE;
        end
        S_LK_EV: begin
          priority if (is_hit) begin
            result.status      <= ST_OK;
            result.found_color <= rd_data.color;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else if (k_is_tail) begin
            result.status <= ST_NOT_FOUND;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            k <= k + IDX_ONE;
          end
        end
        S_RM: begin
          k <= k + IDX_ONE;
          if ((CNT_W'(k) + CNT_TWO) == held_count) begin
            held_count         <= held_count - CNT_ONE;
            result.entry_count <= 5'(held_count - CNT_ONE);
            result.status      <= ST_OK;
            done               <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SICT_ASSERT_NOW(a_count_range, clk, rst, 1'b1, held_count <= CNT_MAX)
  `SICT_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `SICT_ASSERT_NOW(a_write_busy, clk, rst, wr_en, state != S_IDLE)
  `SICT_ASSERT_NEXT(a_empty_lookup, clk, rst, start && !busy && (cmd.op == OP_LOOKUP) && (held_count == '0), done && (result.status == ST_NOT_FOUND))

endmodule

// File: dv/tb_sorted_interval_color_table_unit.sv
module tb_sorted_interval_color_table_unit;
  import sict_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_MAX_INTERVALS;
  localparam int U = 65536;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BLOCK_ITEMS = 50;
  localparam int RANDOM_BLOCKS = 17;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

  typedef enum {PLACE_OVERLAP, PLACE_ABOVE, PLACE_BELOW} placement_t;
  typedef enum {MODE_FILL, MODE_MIX, MODE_DRAIN} stim_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  result_t result;

  entry_t table_entries[TABLE_DEPTH];
  int table_size = 0;
  cmd_t items_to_send[$];
  result_t answers_due[$];
  result_t oldest_answer;
  int idle_left = 0;
  int burst_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  sorted_interval_color_table_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic placement_t placement_of(cmd_t c, int idx);
    logic signed [31:0] nb, ne, eb, ee;
    placement_t p;
    nb = c.range_begin;
    ne = c.range_end;
    eb = table_entries[idx].range_begin;
    ee = table_entries[idx].range_end;
    p = PLACE_OVERLAP;
    if (nb > ee || (nb == ee && (!c.begin_inclusive || !table_entries[idx].end_inclusive)))
      p = PLACE_ABOVE;
    if (ne < eb || (ne == eb && (!c.end_inclusive || !table_entries[idx].begin_inclusive)))
      p = PLACE_BELOW;
    return p;
  endfunction

  function automatic logic entry_holds(int idx, logic signed [31:0] v);
    logic signed [31:0] eb, ee;
    logic lo_ok, hi_ok;
    eb = table_entries[idx].range_begin;
    ee = table_entries[idx].range_end;
    lo_ok = table_entries[idx].begin_inclusive ? (v >= eb) : (v > eb);
    hi_ok = table_entries[idx].end_inclusive ? (v <= ee) : (v < ee);
    return lo_ok && hi_ok;
  endfunction

  function automatic result_t run_table_op(cmd_t c);
    result_t r;
    placement_t p;
    int pos, i, k;
    r.status = ST_OK;
    r.found_color = '0;
    pos = -1;
    case (c.op)
      OP_INSERT: begin
        if (table_size == TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (table_size == 0) begin
          pos = 0;
        end else begin
          p = placement_of(c, table_size - 1);
          if (p == PLACE_OVERLAP) begin
            r.status = ST_OVERLAP;
          end else if (p == PLACE_ABOVE) begin
            pos = table_size;
          end else begin
            pos = 0;
            for (k = table_size - 1; k > 0; k--) begin
              p = placement_of(c, k - 1);
              if (p == PLACE_OVERLAP) begin
                r.status = ST_OVERLAP;
                break;
              end
              if (p == PLACE_ABOVE) begin
                pos = k;
                break;
              end
            end
          end
        end
        if (r.status == ST_OK) begin
          for (i = table_size; i > pos; i--)
            table_entries[i] = table_entries[i - 1];
          table_entries[pos].range_begin = c.range_begin;
          table_entries[pos].range_end = c.range_end;
          table_entries[pos].begin_inclusive = c.begin_inclusive;
          table_entries[pos].end_inclusive = c.end_inclusive;
          table_entries[pos].color = c.entry_color;
          table_size++;
        end
      end
      OP_LOOKUP: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < table_size; i++) begin
          if (entry_holds(i, c.probe_value)) begin
            r.status = ST_OK;
            r.found_color = table_entries[i].color;
            break;
          end
        end
      end
      OP_REMOVE: begin
        if (int'(c.entry_index) >= table_size) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = int'(c.entry_index); i + 1 < table_size; i++)
            table_entries[i] = table_entries[i + 1];
          table_size--;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 5'(table_size);
    return r;
  endfunction

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.op = 2'($urandom());
    c.range_begin = $urandom();
    c.begin_inclusive = 1'($urandom());
    c.range_end = $urandom();
    c.end_inclusive = 1'($urandom());
    c.entry_color = $urandom();
    c.probe_value = $urandom();
    c.entry_index = 4'($urandom());
    return c;
  endfunction

  function automatic void queue_insert(logic signed [31:0] b, logic bi,
                                       logic signed [31:0] e, logic ei);
    cmd_t c;
    c = noise_cmd();
    c.op = OP_INSERT;
    c.range_begin = b;
    c.begin_inclusive = bi;
    c.range_end = e;
    c.end_inclusive = ei;
    items_to_send.insert(items_to_send.size(), c);
  endfunction

  function automatic void queue_lookup(logic signed [31:0] v);
    cmd_t c;
    c = noise_cmd();
    c.op = OP_LOOKUP;
    c.probe_value = v;
    items_to_send.insert(items_to_send.size(), c);
  endfunction

  function automatic void queue_remove(logic [3:0] idx);
    cmd_t c;
    c = noise_cmd();
    c.op = OP_REMOVE;
    c.entry_index = idx;
    items_to_send.insert(items_to_send.size(), c);
  endfunction

  function automatic void queue_unused_op();
    cmd_t c;
    c = noise_cmd();
    c.op = OP_NONE;
    items_to_send.insert(items_to_send.size(), c);
  endfunction

  function automatic void note_failure(string what, result_t want, result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s: expected status %0d color %h count %0d, got status %0d color %h count %0d",
               what, want.status, want.found_color, want.entry_count,
               got.status, got.found_color, got.entry_count);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = draw_gap();
    end else begin
      if (start && !busy) begin
        answers_due.insert(answers_due.size(), run_table_op(cmd));
        idle_left = draw_gap();
      end
      if (!start || !busy) begin
        if (idle_left == 0 && items_to_send.size() != 0) begin
          cmd <= items_to_send.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
          if (idle_left > 0) idle_left--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        note_failure("unexpected result", '0, result);
      end else begin
        oldest_answer = answers_due.pop_front();
        if (result.status !== oldest_answer.status ||
            result.found_color !== oldest_answer.found_color ||
            result.entry_count !== oldest_answer.entry_count)
          note_failure("mismatch", oldest_answer, result);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int blk, n, k, w, r;
    int ins_cut, look_cut, rem_cut;
    stim_mode_t mode;
    logic signed [31:0] b, e, v, t;

    // Directed: empty table, unused code, unbounded ends, touching ends,
    // an inverted interval, boundary lookups, a full table and bad indexes.
    queue_lookup(32'sd0);
    queue_remove(4'd0);
    queue_unused_op();
    queue_insert(VALUE_MIN, 1'b1, -20 * U, 1'b0);
    queue_insert(20 * U, 1'b1, VALUE_MAX, 1'b1);
    queue_insert(-20 * U, 1'b0, -18 * U, 1'b1);
    queue_insert(18 * U, 1'b1, 20 * U, 1'b1);
    queue_insert(18 * U, 1'b1, 20 * U, 1'b0);
    queue_insert(2 * U, 1'b1, -2 * U, 1'b1);
    queue_lookup(VALUE_MIN);
    queue_lookup(VALUE_MAX);
    queue_lookup(20 * U);
    queue_lookup(-20 * U);
    for (k = 0; k < 11; k++)
      queue_insert((-16 + 2 * k) * U, 1'b1, (-15 + 2 * k) * U, 1'b1);
    queue_insert(10 * U, 1'b1, 11 * U, 1'b1);
    queue_remove(4'd15);
    queue_remove(4'd15);

    // Random: blocks that lean toward filling, mixing or draining the table.
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      mode = stim_mode_t'(blk % 3);
      case (mode)
        MODE_FILL: begin
          ins_cut = 65; look_cut = 90; rem_cut = 98;
        end
        MODE_MIX: begin
          ins_cut = 40; look_cut = 75; rem_cut = 97;
        end
        default: begin
          ins_cut = 20; look_cut = 45; rem_cut = 98;
        end
      endcase
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < ins_cut) begin
          k = int'($urandom_range(0, 32)) - 16;
          w = $urandom_range(0, 3);
          b = k * U;
          e = (k + w) * U;
          r = $urandom_range(0, 99);
          if (r < 8) begin
            b = VALUE_MIN;
          end else if (r < 16) begin
            e = VALUE_MAX;
          end else if (r < 22) begin
            t = b;
            b = e;
            e = t;
          end else if (r < 30) begin
            b = $urandom();
            e = $urandom();
          end else if (r < 40) begin
            b = b + $urandom_range(0, U - 1);
            e = e + $urandom_range(0, U - 1);
          end
          queue_insert(b, 1'($urandom()), e, 1'($urandom()));
        end else if (r < look_cut) begin
          k = int'($urandom_range(0, 34)) - 17;
          v = k * U;
          r = $urandom_range(0, 99);
          if (r < 15)
            v = v + $urandom_range(1, U - 1);
          else if (r < 25)
            v = $urandom();
          else if (r < 30)
            v = VALUE_MIN;
          else if (r < 35)
            v = VALUE_MAX;
          else if (r < 42)
            v = v - 1;
          queue_lookup(v);
        end else if (r < rem_cut) begin
          if (mode == MODE_DRAIN && $urandom_range(0, 9) < 7)
            queue_remove(4'($urandom_range(0, 7)));
          else
            queue_remove(4'($urandom()));
        end else begin
          queue_unused_op();
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (items_to_send.size() != 0 || start || answers_due.size() != 0)
      @(posedge clk);
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
